// ===== design/ltad_pkg.sv =====
// Package for the length-tagged Adler-32 deframer.
// Holds widths, command and status codes, the front-to-back command word and helpers.
// No dependencies.
package ltad_pkg;

	localparam int HEADER_BYTES   = 4;
	localparam int CHECKSUM_BYTES = 4;
	localparam int TAG_MAX_BYTES  = 4;
	localparam int TAG_WORD_BYTES = 4;
	localparam int ADLER_MOD      = 65521;

	localparam int LEN_W   = 27;
	localparam int TLEN_W  = 3;
	localparam int CFG_W   = 32;
	localparam int CIDX_W  = 2;
	localparam int SUM_W   = 16;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CIDX_W-1:0] REG_MIN_LENGTH = 2'd0;
	localparam logic [CIDX_W-1:0] REG_MAX_LENGTH = 2'd1;
	localparam logic [CIDX_W-1:0] REG_TAG_LENGTH = 2'd2;
	localparam logic [CIDX_W-1:0] REG_TAG_WORD   = 2'd3;

	localparam logic [LEN_W-1:0]  MIN_LENGTH_RST = 27'd8;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 27'd67108864;
	localparam logic [TLEN_W-1:0] TAG_LENGTH_RST = 3'd4;
	localparam logic [CFG_W-1:0]  TAG_WORD_RST   = 32'd0;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_LEN  = 2'd1;
	localparam logic [1:0] ST_BAD_SUM  = 2'd2;
	localparam logic [1:0] ST_BAD_TAG  = 2'd3;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [1:0] {
		OP_TAG,
		OP_DATA,
		OP_CHECK,
		OP_LENERR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       last;
		logic [7:0] data;
		logic [7:0] expect_byte;
	} cmd_t;

	function automatic logic [7:0] tag_byte(input logic [CFG_W-1:0] word,
		input logic [LEN_W-1:0] idx);
		logic [7:0] b;
		b = 8'd0;
		if (idx < LEN_W'(TAG_WORD_BYTES))
			b = word[CFG_W - 1 - 8 * int'(idx[1:0]) -: 8];
		return b;
	endfunction

	function automatic logic [TLEN_W-1:0] eff_tag_len(input logic [TLEN_W-1:0] tlen);
		return (tlen > TLEN_W'(TAG_MAX_BYTES)) ? TLEN_W'(TAG_MAX_BYTES) : tlen;
	endfunction

endpackage

// ===== design/ltad_if.sv =====
// Handshake channels of the deframer: incoming stream words and outgoing result words.
// Depends on ltad_pkg for nothing but is compiled after it.
interface ltad_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface ltad_result_if;
	logic       valid;
	logic       ready;
	logic       item_kind;
	logic [7:0] payload_byte;
	logic [1:0] frame_status;

	modport source (output valid, output item_kind, output payload_byte,
		output frame_status, input ready);
	modport sink   (input valid, input item_kind, input payload_byte,
		input frame_status, output ready);
endinterface

// ===== design/ltad_front.sv =====
// Front end: configuration registers, header parse, length check and word classification.
// Depends on ltad_pkg and ltad_if; feeds commands to ltad_queue.
module ltad_front (
	input  logic                   clk,
	input  logic                   arst_n,
	ltad_byte_if.sink              frames,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   q_ready,
	output logic                   push,
	output ltad_pkg::cmd_t         cmd
);
	import ltad_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_HALT   = 2'd2;

	logic [LEN_W-1:0]  min_q, max_q;
	logic [TLEN_W-1:0] tlen_q;
	logic [CFG_W-1:0]  tword_q;

	logic [1:0]        phase_q;
	logic [23:0]       hdr_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_q;

	logic              accept;
	logic [31:0]       full_len;
	logic [TLEN_W-1:0] eff;
	logic [3:0]        need;
	logic              bad_len;
	logic [LEN_W-1:0]  data_end;
	logic              body_last;

	assign frames.ready = q_ready;
	assign accept = frames.valid && q_ready;

	assign eff      = eff_tag_len(tlen_q);
	assign need     = {1'b0, eff} + 4'(CHECKSUM_BYTES);
	assign full_len = {hdr_q, frames.stream_byte};
	assign bad_len  = (full_len > {5'd0, max_q}) || (full_len < {5'd0, min_q}) ||
		(full_len < {28'd0, need});
	assign data_end  = len_q - LEN_W'(CHECKSUM_BYTES);
	assign body_last = (idx_q + LEN_W'(1)) == len_q;

	always_comb begin
		push            = 1'b0;
		cmd.op          = OP_DATA;
		cmd.last        = 1'b0;
		cmd.data        = frames.stream_byte;
		cmd.expect_byte = tag_byte(tword_q, idx_q);
		unique case (phase_q)
			PH_HEADER: begin
				if (idx_q[1:0] == 2'(HEADER_BYTES - 1) && bad_len) begin
					push   = accept;
					cmd.op = OP_LENERR;
				end
			end
			PH_BODY: begin
				push = accept;
				if (idx_q < data_end) begin
					if (idx_q < LEN_W'(eff))
						cmd.op = OP_TAG;
					else
						cmd.op = OP_DATA;
				end else begin
					cmd.op   = OP_CHECK;
					cmd.last = body_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= MIN_LENGTH_RST;
			max_q   <= MAX_LENGTH_RST;
			tlen_q  <= TAG_LENGTH_RST;
			tword_q <= TAG_WORD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_LENGTH: min_q   <= cfg_data[LEN_W-1:0];
				REG_MAX_LENGTH: max_q   <= cfg_data[LEN_W-1:0];
				REG_TAG_LENGTH: tlen_q  <= cfg_data[TLEN_W-1:0];
				REG_TAG_WORD:   tword_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			len_q   <= '0;
			hdr_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (idx_q[1:0] == 2'(HEADER_BYTES - 1)) begin
						idx_q <= '0;
						hdr_q <= '0;
						len_q <= full_len[LEN_W-1:0];
						phase_q <= bad_len ? PH_HALT : PH_BODY;
					end else begin
						hdr_q <= {hdr_q[15:0], frames.stream_byte};
						idx_q <= idx_q + LEN_W'(1);
					end
				end
				PH_BODY: begin
					if (idx_q >= data_end && body_last) begin
						idx_q   <= '0;
						phase_q <= PH_HEADER;
					end else begin
						idx_q <= idx_q + LEN_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== design/ltad_queue.sv =====
// Four-entry command queue between front end and back end.
// Depends on ltad_pkg.
module ltad_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ltad_pkg::cmd_t push_cmd,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output ltad_pkg::cmd_t head
);
	import ltad_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign ready  = cnt_q != QCNT_W'(QDEPTH);
	assign valid  = cnt_q != '0;
	assign head   = slot_q[rd_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (!push && do_pop)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

// ===== design/ltad_back.sv =====
// Back end: Adler-32 update, tag and checksum check, sticky halt and output register.
// Depends on ltad_pkg and ltad_if; drains ltad_queue.
module ltad_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  ltad_pkg::cmd_t q_cmd,
	output logic           pop,
	ltad_result_if.source  results
);
	import ltad_pkg::*;

	logic [SUM_W-1:0] low_q, high_q;
	logic [23:0]      rc_q;
	logic             tag_ok_q;
	logic             halt_q;

	logic             out_valid_q;
	logic             kind_q;
	logic [7:0]       pbyte_q;
	logic [1:0]       status_q;

	logic [SUM_W:0]   low_sum, high_sum;
	logic [SUM_W-1:0] low_n, high_n;
	logic             sum_bad;
	logic             emit;
	logic             emit_kind;
	logic [7:0]       emit_byte;
	logic [1:0]       emit_status;

	assign pop = q_valid && (!out_valid_q || results.ready);

	assign low_sum  = {1'b0, low_q} + {9'd0, q_cmd.data};
	assign low_n    = (low_sum >= (SUM_W+1)'(ADLER_MOD)) ?
		SUM_W'(low_sum - (SUM_W+1)'(ADLER_MOD)) : low_sum[SUM_W-1:0];
	assign high_sum = {1'b0, high_q} + {1'b0, low_n};
	assign high_n   = (high_sum >= (SUM_W+1)'(ADLER_MOD)) ?
		SUM_W'(high_sum - (SUM_W+1)'(ADLER_MOD)) : high_sum[SUM_W-1:0];
	assign sum_bad  = {high_q, low_q} != {rc_q, q_cmd.data};

	always_comb begin
		emit        = 1'b0;
		emit_kind   = KIND_STATUS;
		emit_byte   = 8'd0;
		emit_status = ST_OK;
		if (!halt_q) begin
			unique case (q_cmd.op)
				OP_DATA: begin
					emit      = 1'b1;
					emit_kind = KIND_PAYLOAD;
					emit_byte = q_cmd.data;
				end
				OP_CHECK: begin
					emit = q_cmd.last;
					if (sum_bad)
						emit_status = ST_BAD_SUM;
					else if (!tag_ok_q)
						emit_status = ST_BAD_TAG;
				end
				OP_LENERR: begin
					emit        = 1'b1;
					emit_status = ST_BAD_LEN;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= SUM_W'(1);
			high_q      <= '0;
			rc_q        <= '0;
			tag_ok_q    <= 1'b1;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && !halt_q) begin
				unique case (q_cmd.op)
					OP_TAG: begin
						low_q  <= low_n;
						high_q <= high_n;
						if (q_cmd.data != q_cmd.expect_byte)
							tag_ok_q <= 1'b0;
					end
					OP_DATA: begin
						low_q  <= low_n;
						high_q <= high_n;
					end
					OP_CHECK: begin
						if (q_cmd.last) begin
							low_q    <= SUM_W'(1);
							high_q   <= '0;
							rc_q     <= '0;
							tag_ok_q <= 1'b1;
							if (sum_bad || !tag_ok_q)
								halt_q <= 1'b1;
						end else begin
							rc_q <= {rc_q[15:0], q_cmd.data};
						end
					end
					OP_LENERR: halt_q <= 1'b1;
					default: ;
				endcase
			end
			if (pop && emit)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q   <= emit_kind;
			pbyte_q  <= emit_byte;
			status_q <= emit_status;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.item_kind    = kind_q;
	assign results.payload_byte = pbyte_q;
	assign results.frame_status = status_q;

endmodule

// ===== design/length_tag_adler32_deframer.sv =====
// Top level of the length-tagged Adler-32 deframer.
// Depends on ltad_pkg, ltad_if, ltad_front, ltad_queue and ltad_back.
//
// frames carries the received stream one word (byte) per handshake. results carries
// forwarded payload words (item_kind 0) and one frame status per frame (item_kind 1):
// ok, bad length, checksum mismatch or tag mismatch.
// Registers are written through cfg_we/cfg_index/cfg_data. The user must write them only
// while no frame is in flight; the block itself does not enforce it. Throughput: one
// stream word per cycle while the command queue has room, set by the Adler-32 update in
// the back end. An accepted payload word passes the queue slot and the result register.
// A four-word command queue sits between parser and checker. The back end stops taking
// words while a result waits unaccepted in the result register, so a stalled receiver
// only backs up frames.ready once the queue is full.
// Reset clears the parser to the header state, empties the queue, drops any pending
// result and returns registers to their defaults. After any error status the block
// keeps taking words and discards them until the next reset.
module length_tag_adler32_deframer (
	input  logic        clk,
	input  logic        arst_n,
	ltad_byte_if.sink   frames,
	ltad_result_if.source results,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ltad_pkg::*;

	logic q_ready, q_valid, push, pop;
	cmd_t push_cmd, head;

	ltad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.frames   (frames),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_ready  (q_ready),
		.push     (push),
		.cmd      (push_cmd)
	);

	ltad_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.ready   (q_ready),
		.pop     (pop),
		.valid   (q_valid),
		.head    (head)
	);

	ltad_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (head),
		.pop     (pop),
		.results (results)
	);

endmodule
